FILE: src/cowpm_pkg.sv
// Shared constants, codes and control structs of the copy-on-write page mapper.
`timescale 1ns / 1ps
package cowpm_pkg;

    localparam int PROCESS_COUNT     = 2;
    localparam int PAGES_PER_PROCESS = 16;
    localparam int FRAME_COUNT       = 32;
    localparam int ENTRY_COUNT       = PROCESS_COUNT * PAGES_PER_PROCESS;

    localparam int PROC_W   = $clog2(PROCESS_COUNT);
    localparam int PAGE_W   = $clog2(PAGES_PER_PROCESS);
    localparam int ENTRY_W  = $clog2(ENTRY_COUNT);
    localparam int FRAME_W  = 5;
    localparam int RING_W   = $clog2(FRAME_COUNT) + 1;
    localparam int REL_W    = 5;
    localparam int DATA_W   = 32;
    localparam int VA_W     = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // page number sits in address bits 15:12 (mask 0xf000)
    localparam int PAGE_LSB = 12;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_ACCESS  = 2'd0;
    localparam t_op OP_SHARE   = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;

    localparam t_status ST_OK            = 2'd0;
    localparam t_status ST_NO_FRAME      = 2'd1;
    localparam t_status ST_WRITE_DROPPED = 2'd2;

    typedef struct packed {
        logic               pop;
        logic               push;
        logic [FRAME_W-1:0] push_frame;
    } t_ring_cmd;

    typedef struct packed {
        logic               empty;
        logic [FRAME_W-1:0] pop_frame;
    } t_ring_sts;

endpackage

FILE: src/cowpm_req_if.sv
// Request channel: one operation beat into the mapper.
`timescale 1ns / 1ps
interface cowpm_req_if
    import cowpm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [PROC_W-1:0]        process;
    logic [VA_W-1:0]          virtual_address;
    logic                     write_enable;
    logic signed [DATA_W-1:0] store_word;

    modport source (
        output valid, op, process, virtual_address, write_enable, store_word,
        input  ready
    );
    modport sink (
        input  valid, op, process, virtual_address, write_enable, store_word,
        output ready
    );
endinterface

FILE: src/cowpm_rsp_if.sv
// Response channel: one result beat out of the mapper.
`timescale 1ns / 1ps
interface cowpm_rsp_if
    import cowpm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     allocated;
    logic                     copied;
    logic [FRAME_W-1:0]       frame;
    logic signed [DATA_W-1:0] read_data;
    logic [REL_W-1:0]         released_count;

    modport source (
        output valid, status, allocated, copied, frame, read_data, released_count,
        input  ready
    );
    modport sink (
        input  valid, status, allocated, copied, frame, read_data, released_count,
        output ready
    );
endinterface

FILE: src/cowpm_ring.sv
// Free-frame ring: slot memory, head/tail counters and a prefetched head entry.
`timescale 1ns / 1ps
module cowpm_ring
    import cowpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_cmd i_cmd,
    output t_ring_sts o_sts
);

    localparam int SLOT_W = RING_W - 1;

    logic [FRAME_W-1:0]     r_slot_mem [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] r_slot_vld;
    logic [RING_W-1:0]      r_head;
    logic [RING_W-1:0]      r_tail;
    logic [FRAME_W-1:0]     r_pop_q;

    logic [RING_W-1:0] n_head;
    logic [RING_W-1:0] n_tail;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] tail_slot;

    // counters wrap at twice the ring depth, the natural width overflow
    assign n_head    = i_cmd.pop  ? r_head + RING_W'(1) : r_head;
    assign n_tail    = i_cmd.push ? r_tail + RING_W'(1) : r_tail;
    assign head_slot = n_head[SLOT_W-1:0];
    assign tail_slot = r_tail[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= RING_W'(FRAME_COUNT);
            r_slot_vld <= '0;
            r_pop_q    <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            if (i_cmd.push) begin
                r_slot_vld[tail_slot] <= 1'b1;
            end
            // head entry is prefetched into a register; a same-slot push is forwarded
            if (i_cmd.push && (tail_slot == head_slot)) begin
                r_pop_q <= i_cmd.push_frame;
            end else if (r_slot_vld[head_slot]) begin
                r_pop_q <= r_slot_mem[head_slot];
            end else begin
                r_pop_q <= FRAME_W'(head_slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_slot_mem[tail_slot] <= i_cmd.push_frame;
        end
    end

    assign o_sts.empty     = (r_head == r_tail);
    assign o_sts.pop_frame = r_pop_q;

endmodule

FILE: src/copy_on_write_page_mapper.sv
// Top level of the copy-on-write page mapper: sequencer, page table and frame store.
`timescale 1ns / 1ps
// Copy-on-write page mapper for two processes of 16 pages over 32 one-word
// frames. A request beat is taken only while the sequencer is idle; the
// result beat waits in an output register, so the next request is taken
// while an earlier result is still unclaimed. Every operation walks through
// the page-table frame memory (one read and one write port), the frame store
// and the free ring one step at a time: an access goes from the map step
// straight to the result (hit or miss, plain write), passes a read step for a
// read or a copy step for a copy-on-write that finds a frame, and passes both
// for a copy-on-write with an empty ring. Share and release step through the
// 16 table entries one per cycle. A finished result waits in the sequencer,
// and no request is taken, while the output register holds an unclaimed beat.
// Valid bits and read-only bits live in flops; read-only is kept per page,
// since both processes always carry the same value for a page. Frame store
// and ring entries that were never written read back as their own index.
module copy_on_write_page_mapper
    import cowpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cowpm_req_if.sink   i_req,
    cowpm_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_COW,
        S_READ,
        S_WALK,
        S_DONE
    } t_state;

    // sequencer and item registers
    t_state              r_state,   n_state;
    t_op                 r_op,      n_op;
    logic [PROC_W-1:0]   r_proc,    n_proc;
    logic [PAGE_W-1:0]   r_page,    n_page;
    logic                r_wr,      n_wr;
    logic [DATA_W-1:0]   r_wdata,   n_wdata;
    logic [FRAME_W-1:0]  r_frame,   n_frame;
    logic [PAGE_W-1:0]   r_cnt,     n_cnt;
    logic [REL_W-1:0]    r_rel,     n_rel;

    // table flags
    logic [ENTRY_COUNT-1:0]       r_vld, n_vld;
    logic [PAGES_PER_PROCESS-1:0] r_ro,  n_ro;

    // result being built
    t_status             r_res_status, n_res_status;
    logic                r_res_alloc,  n_res_alloc;
    logic                r_res_copied, n_res_copied;
    logic [FRAME_W-1:0]  r_res_frame,  n_res_frame;
    logic [DATA_W-1:0]   r_res_rdata,  n_res_rdata;

    // output register
    logic                r_out_valid,  n_out_valid;
    t_status             r_out_status, n_out_status;
    logic                r_out_alloc,  n_out_alloc;
    logic                r_out_copied, n_out_copied;
    logic [FRAME_W-1:0]  r_out_frame,  n_out_frame;
    logic [DATA_W-1:0]   r_out_rdata,  n_out_rdata;
    logic [REL_W-1:0]    r_out_rel,    n_out_rel;

    // page-table frame memory
    logic [FRAME_W-1:0] r_pt_mem [ENTRY_COUNT];
    logic [FRAME_W-1:0] r_pt_q;
    logic [ENTRY_W-1:0] pt_ra;
    logic               pt_we;
    logic [ENTRY_W-1:0] pt_wa;
    logic [FRAME_W-1:0] pt_wd;

    // frame store
    logic [DATA_W-1:0]      r_dm_mem [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] r_dm_vld;
    logic [DATA_W-1:0]      r_dm_q;
    logic [FRAME_W-1:0]     dm_ra;
    logic                   dm_we;
    logic [FRAME_W-1:0]     dm_wa;
    logic [DATA_W-1:0]      dm_wd;

    t_ring_cmd ring_cmd;
    t_ring_sts ring_sts;

    logic in_ready;
    logic out_free;

    cowpm_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .o_sts   (ring_sts)
    );

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        logic [ENTRY_W-1:0] ent;
        logic [ENTRY_W-1:0] walk_ent;
        logic [FRAME_W-1:0] f;
        logic [PROC_W-1:0]  req_proc;
        logic [PAGE_W-1:0]  req_page;

        n_state      = r_state;
        n_op         = r_op;
        n_proc       = r_proc;
        n_page       = r_page;
        n_wr         = r_wr;
        n_wdata      = r_wdata;
        n_frame      = r_frame;
        n_cnt        = r_cnt;
        n_rel        = r_rel;
        n_vld        = r_vld;
        n_ro         = r_ro;
        n_res_status = r_res_status;
        n_res_alloc  = r_res_alloc;
        n_res_copied = r_res_copied;
        n_res_frame  = r_res_frame;
        n_res_rdata  = r_res_rdata;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_alloc  = r_out_alloc;
        n_out_copied = r_out_copied;
        n_out_frame  = r_out_frame;
        n_out_rdata  = r_out_rdata;
        n_out_rel    = r_out_rel;

        ent      = {r_proc, r_page};
        walk_ent = {r_proc, r_cnt};
        f        = r_pt_q;
        req_proc = (i_req.op == OP_SHARE) ? PROC_W'(0) : i_req.process;
        req_page = (i_req.op == OP_ACCESS) ? i_req.virtual_address[PAGE_LSB +: PAGE_W]
                                           : PAGE_W'(0);

        pt_ra    = ent;
        pt_we    = 1'b0;
        pt_wa    = ent;
        pt_wd    = r_pt_q;
        dm_ra    = r_frame;
        dm_we    = 1'b0;
        dm_wa    = r_frame;
        dm_wd    = r_wdata;
        ring_cmd = '0;
        in_ready = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                pt_ra    = {req_proc, req_page};
                if (i_req.valid) begin
                    n_op         = i_req.op;
                    n_proc       = req_proc;
                    n_page       = req_page;
                    n_wr         = i_req.write_enable;
                    n_wdata      = i_req.store_word;
                    n_cnt        = '0;
                    n_rel        = '0;
                    n_res_status = ST_OK;
                    n_res_alloc  = 1'b0;
                    n_res_copied = 1'b0;
                    n_res_frame  = '0;
                    n_res_rdata  = '0;
                    unique case (i_req.op)
                        OP_ACCESS: begin
                            n_state = S_MAP;
                        end
                        OP_SHARE: begin
                            // flags copy at once; frame numbers follow in the walk
                            n_ro = '1;
                            n_vld[ENTRY_COUNT-1:PAGES_PER_PROCESS] =
                                r_vld[PAGES_PER_PROCESS-1:0];
                            n_state = S_WALK;
                        end
                        OP_RELEASE: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_MAP: begin
                if (!r_vld[ent] && ring_sts.empty) begin
                    n_res_status = ST_NO_FRAME;
                    n_state      = S_DONE;
                end else begin
                    if (!r_vld[ent]) begin
                        f            = ring_sts.pop_frame;
                        ring_cmd.pop = 1'b1;
                        n_vld[ent]   = 1'b1;
                        pt_we        = 1'b1;
                        pt_wd        = f;
                        n_res_alloc  = 1'b1;
                    end
                    n_frame = f;
                    if (r_wr && !r_ro[r_page]) begin
                        dm_we       = 1'b1;
                        dm_wa       = f;
                        n_res_frame = f;
                        n_res_rdata = r_wdata;
                        n_state     = S_DONE;
                    end else if (r_wr) begin
                        n_state = S_COW;
                    end else begin
                        dm_ra   = f;
                        n_state = S_READ;
                    end
                end
            end

            S_COW: begin
                n_ro[r_page] = 1'b0;
                if (ring_sts.empty) begin
                    // write dropped, page keeps its frame
                    n_res_status = ST_WRITE_DROPPED;
                    n_state      = S_READ;
                end else begin
                    ring_cmd.pop = 1'b1;
                    pt_we        = 1'b1;
                    pt_wd        = ring_sts.pop_frame;
                    dm_we        = 1'b1;
                    dm_wa        = ring_sts.pop_frame;
                    n_res_copied = 1'b1;
                    n_res_frame  = ring_sts.pop_frame;
                    n_res_rdata  = r_wdata;
                    n_state      = S_DONE;
                end
            end

            S_READ: begin
                n_res_frame = r_frame;
                n_res_rdata = r_dm_q;
                n_state     = S_DONE;
            end

            S_WALK: begin
                // r_pt_q holds entry r_cnt; fetch the next one
                pt_ra = {r_proc, r_cnt + PAGE_W'(1)};
                if (r_op == OP_SHARE) begin
                    pt_we = 1'b1;
                    pt_wa = {PROC_W'(1), r_cnt};
                    pt_wd = r_pt_q;
                end else if (r_vld[walk_ent]) begin
                    ring_cmd.push       = 1'b1;
                    ring_cmd.push_frame = r_pt_q;
                    n_vld[walk_ent]     = 1'b0;
                    n_rel               = r_rel + REL_W'(1);
                end
                if (r_cnt == PAGE_W'(PAGES_PER_PROCESS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + PAGE_W'(1);
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_alloc  = r_res_alloc;
                    n_out_copied = r_res_copied;
                    n_out_frame  = r_res_frame;
                    n_out_rdata  = r_res_rdata;
                    n_out_rel    = r_rel;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_ro        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_ro        <= n_ro;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_proc       <= n_proc;
        r_page       <= n_page;
        r_wr         <= n_wr;
        r_wdata      <= n_wdata;
        r_frame      <= n_frame;
        r_cnt        <= n_cnt;
        r_rel        <= n_rel;
        r_res_status <= n_res_status;
        r_res_alloc  <= n_res_alloc;
        r_res_copied <= n_res_copied;
        r_res_frame  <= n_res_frame;
        r_res_rdata  <= n_res_rdata;
        r_out_status <= n_out_status;
        r_out_alloc  <= n_out_alloc;
        r_out_copied <= n_out_copied;
        r_out_frame  <= n_out_frame;
        r_out_rdata  <= n_out_rdata;
        r_out_rel    <= n_out_rel;
    end

    // page-table frame numbers: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_wa] <= pt_wd;
        end
        r_pt_q <= r_pt_mem[pt_ra];
    end

    // frame store; an unwritten frame holds its own number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dm_vld <= '0;
        end else if (dm_we) begin
            r_dm_vld[dm_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dm_mem[dm_wa] <= dm_wd;
        end
        r_dm_q <= r_dm_vld[dm_ra] ? r_dm_mem[dm_ra] : DATA_W'(dm_ra);
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.allocated      = r_out_alloc;
    assign o_rsp.copied         = r_out_copied;
    assign o_rsp.frame          = r_out_frame;
    assign o_rsp.read_data      = r_out_rdata;
    assign o_rsp.released_count = r_out_rel;

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_cmd.pop |-> !ring_sts.empty)
        else $error("pop from empty free ring");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one is in flight");

    a_miss_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_NO_FRAME)) |->
            (!o_rsp.allocated && !o_rsp.copied && (o_rsp.frame == '0)))
        else $error("out-of-frames result carries a mapping");

    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.copied) |-> (o_rsp.status == ST_OK))
        else $error("copy-on-write reported with error status");

    a_walk_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_cmd.push |-> ((r_state == S_WALK) && (r_op == OP_RELEASE)))
        else $error("ring push outside release walk");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for the copy-on-write page mapper: random and directed beats, scoreboard.
`timescale 1ns / 1ps

import cowpm_pkg::*;

typedef struct packed {
    t_op                op;
    logic [PROC_W-1:0]  proc;
    logic [VA_W-1:0]    virtual_address;
    logic               write_enable;
    logic [DATA_W-1:0]  store_word;
} t_map_req;

typedef struct packed {
    t_status            status;
    logic               allocated;
    logic               copied;
    logic [FRAME_W-1:0] frame;
    logic [DATA_W-1:0]  read_data;
    logic [REL_W-1:0]   released_count;
} t_map_rsp;

// Mirrors page table, frame store and free ring; holds the results still owed by the mapper.
class page_map_scoreboard;
    bit               page_valid [PROCESS_COUNT][PAGES_PER_PROCESS];
    bit [FRAME_W-1:0] page_frame [PROCESS_COUNT][PAGES_PER_PROCESS];
    bit               page_ro    [PROCESS_COUNT][PAGES_PER_PROCESS];
    bit [DATA_W-1:0]  frame_word [FRAME_COUNT];
    bit [FRAME_W-1:0] free_ring  [FRAME_COUNT];
    bit [RING_W-1:0]  ring_head;
    bit [RING_W-1:0]  ring_tail;
    t_map_rsp         owed_results[$];
    int               error_count;
    int               result_index;

    function new();
        for (int f = 0; f < FRAME_COUNT; f++) begin
            frame_word[f] = f;
            free_ring[f]  = FRAME_W'(f);
        end
        ring_head = '0;
        ring_tail = RING_W'(FRAME_COUNT);    // ring starts full
    endfunction

    // head/tail count modulo 2*FRAME_COUNT, slot is the low bits
    function bit [FRAME_W-1:0] take_free_frame();
        bit [FRAME_W-1:0] f;
        f = free_ring[ring_head[FRAME_W-1:0]];
        ring_head = ring_head + RING_W'(1);
        return f;
    endfunction

    function void accept_request(t_map_req r);
        t_map_rsp m;
        int       p;
        int       g;
        bit       mapped;
        m      = '0;
        p      = int'(r.proc);
        g      = int'(r.virtual_address[VA_W-1:PAGE_LSB]);
        mapped = 1'b1;
        case (r.op)
            OP_ACCESS: begin
                if (!page_valid[p][g]) begin
                    if (ring_head == ring_tail) begin
                        m.status = ST_NO_FRAME;
                        mapped   = 1'b0;
                    end else begin
                        page_frame[p][g] = take_free_frame();
                        page_valid[p][g] = 1'b1;
                        m.allocated      = 1'b1;
                    end
                end
                if (mapped) begin
                    if (r.write_enable && page_ro[p][g]) begin
                        if (ring_head != ring_tail) begin
                            page_frame[p][g] = take_free_frame();
                            frame_word[page_frame[p][g]] = r.store_word;
                            m.copied = 1'b1;
                        end else begin
                            m.status = ST_WRITE_DROPPED;
                        end
                        // sharing is broken for both owners, even when the write was dropped
                        page_ro[p][g]     = 1'b0;
                        page_ro[p ^ 1][g] = 1'b0;
                    end else if (r.write_enable) begin
                        frame_word[page_frame[p][g]] = r.store_word;
                    end
                    m.frame     = page_frame[p][g];
                    m.read_data = frame_word[m.frame];
                end
            end
            OP_SHARE: begin
                for (int n = 0; n < PAGES_PER_PROCESS; n++) begin
                    page_ro[0][n]    = 1'b1;
                    page_ro[1][n]    = 1'b1;
                    page_valid[1][n] = page_valid[0][n];
                    page_frame[1][n] = page_frame[0][n];
                end
            end
            OP_RELEASE: begin
                // no overflow guard: tail may run past head and clobber slots
                for (int n = 0; n < PAGES_PER_PROCESS; n++) begin
                    if (page_valid[p][n]) begin
                        free_ring[ring_tail[FRAME_W-1:0]] = page_frame[p][n];
                        ring_tail        = ring_tail + RING_W'(1);
                        page_valid[p][n] = 1'b0;
                        page_frame[p][n] = '0;
                        m.released_count = m.released_count + REL_W'(1);
                    end
                end
            end
            default: ;
        endcase
        owed_results.push_back(m);
    endfunction

    function void note_error(string msg);
        error_count++;
        if (error_count <= 10) $display("tb_top: result %0d: %s", result_index, msg);
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) note_error($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    function void check_response(t_map_rsp got);
        t_map_rsp want;
        result_index++;
        if (owed_results.size() == 0) begin
            note_error($sformatf("unexpected result beat %h", got));
            return;
        end
        want = owed_results.pop_front();
        check_field("status",         DATA_W'(want.status),    DATA_W'(got.status));
        check_field("allocated",      DATA_W'(want.allocated), DATA_W'(got.allocated));
        check_field("copied",         DATA_W'(want.copied),    DATA_W'(got.copied));
        check_field("frame",          DATA_W'(want.frame),     DATA_W'(got.frame));
        check_field("read_data",      want.read_data,          got.read_data);
        check_field("released_count", DATA_W'(want.released_count),
                    DATA_W'(got.released_count));
    endfunction
endclass

module tb_top;

    localparam int  CLK_PERIOD_NS  = 12;
    localparam int  RESET_CYCLES   = 5;
    localparam int  DIRECTED_ITEMS = 29;
    localparam int  RANDOM_ITEMS   = 1325;
    localparam int  PLANNED_ITEMS  = DIRECTED_ITEMS + RANDOM_ITEMS;
    // long receiver hold-off; the mapper buffers little, so the request side backs up
    localparam int  HOLD_CYCLES    = 250;
    // margin after the last owed result, for a stray extra beat to show up
    localparam int  TAIL_CYCLES    = 40;
    localparam int  TIMEOUT_NS     = 8_000_000;
    localparam t_op OP_UNUSED      = 2'd3;

    logic i_clk;
    logic i_rst_n;

    cowpm_req_if req_bus ();
    cowpm_rsp_if rsp_bus ();

    copy_on_write_page_mapper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    page_map_scoreboard map_sb;

    int beats_sent;
    int sender_idle_pct;
    int receiver_idle_pct;
    bit rsp_hold_request;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------

    // Data words lean on the sign and all-ones corners now and then.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_map_req access_req(bit proc, int page, bit we,
                                            logic [DATA_W-1:0] data, logic [11:0] offset);
        t_map_req r;
        r.op              = OP_ACCESS;
        r.proc            = proc;
        r.virtual_address = {page[3:0], offset};
        r.write_enable    = we;
        r.store_word      = data;
        return r;
    endfunction

    // Table-wide ops; address, write flag and data are don't-care, so scramble them.
    function automatic t_map_req table_req(t_op op, bit proc);
        t_map_req r;
        r.op              = op;
        r.proc            = proc;
        r.virtual_address = VA_W'($urandom);
        r.write_enable    = 1'($urandom_range(1));
        r.store_word      = $urandom;
        return r;
    endfunction

    function automatic t_map_req rand_access();
        return access_req(1'($urandom_range(1)), int'($urandom_range(15)),
                          1'($urandom_range(1)), rand_word(), 12'($urandom_range(4095)));
    endfunction

    // ------------------------------------------------------------------
    // Request driver: drive at the falling edge, accept at the rising edge.
    // Idle pattern follows the traffic phase: receiver-heavy gaps first, then
    // sender-heavy gaps the other way round, then full rate.
    // ------------------------------------------------------------------
    task automatic send_item(input t_map_req item);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid           <= 1'b1;
        req_bus.op              <= item.op;
        req_bus.process         <= item.proc;
        req_bus.virtual_address <= item.virtual_address;
        req_bus.write_enable    <= item.write_enable;
        req_bus.store_word      <= item.store_word;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
        map_sb.accept_request(item);
        beats_sent++;
        if (beats_sent < PLANNED_ITEMS / 3) begin
            sender_idle_pct   = 30;
            receiver_idle_pct = 73;
        end else if (beats_sent < 2 * PLANNED_ITEMS / 3) begin
            sender_idle_pct   = 73;
            receiver_idle_pct = 30;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
        // back-pressure episodes: one in the busy middle, one at full rate
        if (beats_sent == PLANNED_ITEMS / 2 || beats_sent == 5 * PLANNED_ITEMS / 6)
            rsp_hold_request = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, plus the long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : result_sink
        t_map_rsp got;
        bit       take;
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rsp_hold_request) begin
                rsp_hold_request = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            take = ($urandom_range(99) >= receiver_idle_pct);
            rsp_bus.ready <= take;
            @(posedge i_clk);
            if (take && rsp_bus.valid === 1'b1) begin
                got.status         = rsp_bus.status;
                got.allocated      = rsp_bus.allocated;
                got.copied         = rsp_bus.copied;
                got.frame          = rsp_bus.frame;
                got.read_data      = rsp_bus.read_data;
                got.released_count = rsp_bus.released_count;
                map_sb.check_response(got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                random_sent;
        int                pick;
        int                len;
        bit                who;
        t_map_req          r;
        logic [DATA_W-1:0] dword;

        map_sb                  = new();
        beats_sent              = 0;
        sender_idle_pct         = 30;
        receiver_idle_pct       = 73;
        rsp_hold_request        = 1'b0;
        i_rst_n                 = 1'b0;
        req_bus.valid           = 1'b0;
        req_bus.op              = OP_ACCESS;
        req_bus.process         = '0;
        req_bus.virtual_address = '0;
        req_bus.write_enable    = 1'b0;
        req_bus.store_word      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // Fill every page of process 0: alternating reads and writes, address
        // offsets at both ends, data at the signed corners. Uses 16 frames.
        for (int pg = 0; pg < PAGES_PER_PROCESS; pg++) begin
            case (pg % 4)
                0:       dword = 32'h8000_0000;
                1:       dword = 32'h7FFF_FFFF;
                2:       dword = 32'hFFFF_FFFF;
                default: dword = $urandom;
            endcase
            send_item(access_req(1'b0, pg, pg[0], dword, pg[0] ? 12'hFFF : 12'h000));
        end

        // undefined opcode with every other field high: must change nothing
        r.op              = OP_UNUSED;
        r.proc            = 1'b1;
        r.virtual_address = 16'hFFFF;
        r.write_enable    = 1'b1;
        r.store_word      = 32'hFFFF_FFFF;
        send_item(r);

        // Share then release process 1, three times over. Each release pushes
        // process 0's 16 frames again with no pops, so the ring count wraps
        // all the way round and the ring looks empty.
        send_item(table_req(OP_SHARE, 1'b1));
        send_item(table_req(OP_RELEASE, 1'b1));
        send_item(table_req(OP_SHARE, 1'b0));
        send_item(table_req(OP_RELEASE, 1'b1));
        send_item(table_req(OP_SHARE, 1'b0));
        send_item(table_req(OP_RELEASE, 1'b1));

        // miss with no free frame
        send_item(access_req(1'b1, 3, 1'b0, 32'h1234_5678, 12'h0A5));
        // write to a shared page, no frame for the copy: dropped, sharing cleared
        send_item(access_req(1'b0, 7, 1'b1, 32'hDEAD_BEEF, 12'h5A0));
        // same page again is now a plain write
        send_item(access_req(1'b0, 7, 1'b1, 32'h0BAD_F00D, 12'hFFF));
        // release keeps read-only bits, so the next misses also copy on write
        send_item(table_req(OP_RELEASE, 1'b0));
        send_item(access_req(1'b0, 2, 1'b1, 32'h8000_0001, 12'h000));
        send_item(access_req(1'b1, 9, 1'b1, 32'h7FFF_FFFE, 12'h800));

        // --- random part ---
        // Mostly well-formed traffic (access bursts, share-then-write, table
        // sweeps, ring wrap via repeated share/release) with some noise.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = $urandom_range(4, 16);
                repeat (len) send_item(rand_access());
                random_sent += len;
            end else if (pick < 62) begin
                // share, then mostly writes that split the shared pages
                send_item(table_req(OP_SHARE, 1'($urandom_range(1))));
                len = $urandom_range(3, 10);
                repeat (len)
                    send_item(access_req(1'($urandom_range(1)), int'($urandom_range(15)),
                                         $urandom_range(3) != 0, rand_word(),
                                         12'($urandom_range(4095))));
                random_sent += len + 1;
            end else if (pick < 72) begin
                send_item(table_req(OP_RELEASE, 1'($urandom_range(1))));
                random_sent++;
            end else if (pick < 79) begin
                // repeated share/release of process 1 overruns the ring
                len = $urandom_range(1, 4);
                repeat (len) begin
                    send_item(table_req(OP_SHARE, 1'($urandom_range(1))));
                    send_item(table_req(OP_RELEASE, 1'b1));
                end
                random_sent += 2 * len;
            end else if (pick < 90) begin
                // walk all pages of one process in order
                who = 1'($urandom_range(1));
                for (int pg = 0; pg < PAGES_PER_PROCESS; pg++)
                    send_item(access_req(who, pg, 1'($urandom_range(1)), rand_word(),
                                         12'($urandom_range(4095))));
                random_sent += PAGES_PER_PROCESS;
            end else begin
                // noise: any opcode, any fields
                r.op              = OP_W'($urandom_range(3));
                r.proc            = PROC_W'($urandom_range(1));
                r.virtual_address = VA_W'($urandom);
                r.write_enable    = 1'($urandom_range(1));
                r.store_word      = $urandom;
                send_item(r);
                if (r.op != OP_UNUSED) random_sent++;
            end
        end

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (map_sb.owed_results.size() != 0) @(posedge i_clk);
        // let any stray late beat show up before judging
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (map_sb.error_count == 0 && map_sb.owed_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
src/cowpm_pkg.sv
src/cowpm_req_if.sv
src/cowpm_rsp_if.sv
src/cowpm_ring.sv
src/copy_on_write_page_mapper.sv
dv/tb_top.sv
